FILE: rtl/rfcs_pkg.sv
// Shared constants, types and the field extraction function of the report field change scanner.
// No dependencies; the top level, controller and datapath import this package.
`timescale 1ns / 1ps

package rfcs_pkg;

	// Store sizes
	localparam int MAX_FIELDS   = 32;
	localparam int REPORT_BYTES = 32;
	localparam int MAX_RESULTS  = 32;

	// Field widths of items and results
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 5;
	localparam int OFFSET_W = 8;
	localparam int NBITS_W  = 6;
	localparam int BIDX_W   = 5;
	localparam int BYTE_W   = 8;
	localparam int VALUE_W  = 32;
	localparam int CFG_W    = 6;

	// Derived widths
	localparam int DESC_AW  = $clog2(MAX_FIELDS);
	localparam int BYTE_AW  = $clog2(REPORT_BYTES);
	localparam int FIDX_W   = $clog2(MAX_FIELDS + 1);
	localparam int CNT_W    = $clog2(MAX_RESULTS + 1);
	localparam int SHIFT_W  = $clog2(BYTE_W);

	// A field of up to VALUE_W bits at any bit phase spans this many bytes
	localparam int SPAN_BYTES = (VALUE_W + BYTE_W - 1 + BYTE_W - 1) / BYTE_W;
	localparam int SPAN_W     = SPAN_BYTES * BYTE_W;
	localparam int SPAN_CW    = $clog2(SPAN_BYTES);

	// Stream packing
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 72;

	// APB port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_FIELD_COUNT = 1'b0;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_DESC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PREV = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CURR = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SCAN = 2'd3;

	typedef struct packed {
		logic [NBITS_W-1:0]  nbits;
		logic [OFFSET_W-1:0] offset;
	} desc_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_desc;
		logic wr_prev;
		logic wr_curr;
		logic scan_init;
		logic desc_rd;
		logic desc_cap;
		logic byte_rd;
		logic extract;
		logic push;
		logic flush;
		logic next_field;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fidx_zero;
		logic cnt_full;
		logic span_last;
		logic diff;
		logic pend;
		logic out_free;
	} ctrl_sts_t;

	// Take a field out of a byte span: shift by the bit phase, keep nbits (saturated)
	function automatic logic [VALUE_W-1:0] field_value(
		input logic [SPAN_W-1:0]  span,
		input logic [SHIFT_W-1:0] phase,
		input logic [NBITS_W-1:0] nbits
	);
		logic [SPAN_W-1:0]  shifted;
		logic [VALUE_W-1:0] mask;
		shifted = span >> phase;
		if (nbits >= NBITS_W'(VALUE_W)) begin
			mask = '1;
		end else begin
			mask = (VALUE_W'(1) << nbits[$clog2(VALUE_W)-1:0]) - VALUE_W'(1);
		end
		return shifted[VALUE_W-1:0] & mask;
	endfunction

endpackage

FILE: rtl/report_field_change_scanner_top.sv
// Top level of the report field change scanner: stream ports, APB register, controller and datapath.
// Depends on rfcs_pkg, rfcs_ctrl, rfcs_dp (and rfcs_ram through the datapath).
//
//   Channel   Direction  Carries
//   s_axis    in         load descriptor, load previous/current report byte, or scan
//   m_axis    out        one item per changed field, or one not-found item; tlast on the final one
//   apb       in/out     field_count register at byte address 0
//
// A load item is written straight into its store. A scan item walks each descriptor in use
// through a descriptor read, five byte reads of both report RAMs, extract and compare,
// one descriptor after the next, through the single read port of each report RAM.
// No item is taken while a scan runs; a stalled m_axis holds the scan at its next result.
// Reset clears the controller, counters and field_count; the stores are not cleared.
`timescale 1ns / 1ps

module report_field_change_scanner_top
	import rfcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Stream in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// desc_index[4:0], field_offset[12:5], field_bits[18:13], byte_index[23:19],
	// report_byte[31:24]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [KIND_W-1:0]     s_axis_tuser,
	// Stream out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// changed_index[4:0], new_value[36:5], old_value[68:37], zero[71:69]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// found[0]
	output logic                  m_axis_tuser,
	output logic                  m_axis_tlast,
	// APB
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	ctrl_cmd_t          cmd;
	ctrl_sts_t          sts;
	logic [CFG_W-1:0]   field_count_q;
	logic [IDX_W-1:0]   out_index;
	logic [VALUE_W-1:0] out_new;
	logic [VALUE_W-1:0] out_old;

	// Register write and read
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FIELD_COUNT)) begin
			field_count_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_FIELD_COUNT) ? PDATA_W'(field_count_q) : '0;

	rfcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	rfcs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.field_count  (field_count_q),
		.desc_index   (s_axis_tdata[4:0]),
		.field_offset (s_axis_tdata[12:5]),
		.field_bits   (s_axis_tdata[18:13]),
		.byte_index   (s_axis_tdata[23:19]),
		.report_byte  (s_axis_tdata[31:24]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_found    (m_axis_tuser),
		.out_index    (out_index),
		.out_new      (out_new),
		.out_old      (out_old),
		.out_last     (m_axis_tlast)
	);

	// Pack result fields, lowest first
	assign m_axis_tdata = {3'b000, out_old, out_new, out_index};

endmodule

FILE: rtl/rfcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rfcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/rfcs_ctrl.sv
// Controller of the report field change scanner: takes items and sequences the scan.
// Depends on rfcs_pkg; drives the command struct of rfcs_dp.
`timescale 1ns / 1ps

module rfcs_ctrl
	import rfcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] in_kind,
	input  ctrl_sts_t         sts,
	output ctrl_cmd_t         cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NEXT  = 3'd1;
	localparam logic [2:0] S_DESC  = 3'd2;
	localparam logic [2:0] S_BYTE  = 3'd3;
	localparam logic [2:0] S_TAIL  = 3'd4;
	localparam logic [2:0] S_EXT   = 3'd5;
	localparam logic [2:0] S_CHK   = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_DESC: cmd.wr_desc = 1'b1;
						KIND_PREV: cmd.wr_prev = 1'b1;
						KIND_CURR: cmd.wr_curr = 1'b1;
						default: begin
							cmd.scan_init = 1'b1;
							state_d       = S_NEXT;
						end
					endcase
				end
			end
			S_NEXT: begin
				if (sts.fidx_zero || sts.cnt_full) begin
					state_d = S_FLUSH;
				end else begin
					cmd.desc_rd = 1'b1;
					state_d     = S_DESC;
				end
			end
			S_DESC: begin
				cmd.desc_cap = 1'b1;
				state_d      = S_BYTE;
			end
			S_BYTE: begin
				cmd.byte_rd = 1'b1;
				if (sts.span_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = S_EXT;
			end
			S_EXT: begin
				cmd.extract = 1'b1;
				state_d     = S_CHK;
			end
			S_CHK: begin
				// Hold while an earlier result still occupies the output register
				if (!sts.diff) begin
					cmd.next_field = 1'b1;
					state_d        = S_NEXT;
				end else if (!sts.pend || sts.out_free) begin
					cmd.push       = 1'b1;
					cmd.next_field = 1'b1;
					state_d        = S_NEXT;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/rfcs_dp.sv
// Datapath of the report field change scanner: descriptor and report RAMs, byte span
// assembly, field extraction, pending result and output register. Depends on rfcs_pkg, rfcs_ram.
`timescale 1ns / 1ps

module rfcs_dp
	import rfcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output ctrl_sts_t           sts,
	input  logic [CFG_W-1:0]    field_count,
	input  logic [IDX_W-1:0]    desc_index,
	input  logic [OFFSET_W-1:0] field_offset,
	input  logic [NBITS_W-1:0]  field_bits,
	input  logic [BIDX_W-1:0]   byte_index,
	input  logic [BYTE_W-1:0]   report_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_found,
	output logic [IDX_W-1:0]    out_index,
	output logic [VALUE_W-1:0]  out_new,
	output logic [VALUE_W-1:0]  out_old,
	output logic                out_last
);

	desc_t                desc_wdata;
	desc_t                desc_rdata;
	logic                 desc_we;
	logic [BYTE_W-1:0]    prev_rdata;
	logic [BYTE_W-1:0]    curr_rdata;

	logic [FIDX_W-1:0]    fidx_q;
	logic [FIDX_W-1:0]    fidx_m1;
	logic [CNT_W-1:0]     cnt_q;
	logic [SPAN_CW-1:0]   span_q;
	logic [BYTE_AW-1:0]   baddr_q;
	logic [OFFSET_W-1:0]  off_q;
	logic [NBITS_W-1:0]   nbits_q;
	logic                 cap_s1;
	logic [SPAN_W-1:0]    prev_span_q;
	logic [SPAN_W-1:0]    curr_span_q;
	logic [VALUE_W-1:0]   old_q;
	logic [VALUE_W-1:0]   new_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic [VALUE_W-1:0]   pend_new_q;
	logic [VALUE_W-1:0]   pend_old_q;
	logic                 out_valid_q;
	logic                 out_found_q;
	logic [IDX_W-1:0]     out_index_q;
	logic [VALUE_W-1:0]   out_new_q;
	logic [VALUE_W-1:0]   out_old_q;
	logic                 out_last_q;
	logic                 out_free;

	assign fidx_m1 = fidx_q - FIDX_W'(1);

	// Descriptor store; slots beyond the table are dropped
	assign desc_wdata.nbits  = field_bits;
	assign desc_wdata.offset = field_offset;
	assign desc_we = cmd.wr_desc && (int'(desc_index) < MAX_FIELDS);

	rfcs_ram #(.WIDTH($bits(desc_t)), .DEPTH(MAX_FIELDS)) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (desc_index[DESC_AW-1:0]),
		.wdata (desc_wdata),
		.re    (cmd.desc_rd),
		.raddr (fidx_m1[DESC_AW-1:0]),
		.rdata (desc_rdata)
	);

	// Previous and current report stores, read in step at the same byte address
	rfcs_ram #(.WIDTH(BYTE_W), .DEPTH(REPORT_BYTES)) u_prev_ram (
		.clk   (clk),
		.we    (cmd.wr_prev),
		.waddr (byte_index[BYTE_AW-1:0]),
		.wdata (report_byte),
		.re    (cmd.byte_rd),
		.raddr (baddr_q),
		.rdata (prev_rdata)
	);

	rfcs_ram #(.WIDTH(BYTE_W), .DEPTH(REPORT_BYTES)) u_curr_ram (
		.clk   (clk),
		.we    (cmd.wr_curr),
		.waddr (byte_index[BYTE_AW-1:0]),
		.wdata (report_byte),
		.re    (cmd.byte_rd),
		.raddr (baddr_q),
		.rdata (curr_rdata)
	);

	// Field and result counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q <= '0;
			cnt_q  <= '0;
			cap_s1 <= 1'b0;
		end else begin
			cap_s1 <= cmd.byte_rd;
			if (cmd.scan_init) begin
				if (int'(field_count) > MAX_FIELDS) begin
					fidx_q <= FIDX_W'(MAX_FIELDS);
				end else begin
					fidx_q <= FIDX_W'(field_count);
				end
			end else if (cmd.next_field) begin
				fidx_q <= fidx_m1;
			end
			if (cmd.flush) begin
				cnt_q <= '0;
			end else if (cmd.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Latch descriptor, walk the byte span, shift in bytes one read behind
	always_ff @(posedge clk) begin
		if (cmd.desc_cap) begin
			off_q   <= desc_rdata.offset;
			nbits_q <= desc_rdata.nbits;
			baddr_q <= BYTE_AW'(desc_rdata.offset[OFFSET_W-1:SHIFT_W]);
			span_q  <= '0;
		end else if (cmd.byte_rd) begin
			baddr_q <= baddr_q + BYTE_AW'(1);
			span_q  <= span_q + SPAN_CW'(1);
		end
		if (cap_s1) begin
			prev_span_q <= {prev_rdata, prev_span_q[SPAN_W-1:BYTE_W]};
			curr_span_q <= {curr_rdata, curr_span_q[SPAN_W-1:BYTE_W]};
		end
		if (cmd.extract) begin
			old_q <= field_value(prev_span_q, off_q[SHIFT_W-1:0], nbits_q);
			new_q <= field_value(curr_span_q, off_q[SHIFT_W-1:0], nbits_q);
		end
		// Hold the latest change until the next one shows whether it is the final result
		if (cmd.push) begin
			pend_idx_q <= fidx_m1[IDX_W-1:0];
			pend_new_q <= new_q;
			pend_old_q <= old_q;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.push && (cnt_q != '0)) || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && (cnt_q != '0)) begin
			out_found_q <= 1'b1;
			out_index_q <= pend_idx_q;
			out_new_q   <= pend_new_q;
			out_old_q   <= pend_old_q;
			out_last_q  <= 1'b0;
		end else if (cmd.flush) begin
			out_found_q <= (cnt_q != '0);
			out_index_q <= (cnt_q != '0) ? pend_idx_q : '0;
			out_new_q   <= (cnt_q != '0) ? pend_new_q : '0;
			out_old_q   <= (cnt_q != '0) ? pend_old_q : '0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_index = out_index_q;
	assign out_new   = out_new_q;
	assign out_old   = out_old_q;
	assign out_last  = out_last_q;

	// Status back to the controller
	assign sts.fidx_zero = (fidx_q == '0);
	assign sts.cnt_full  = (int'(cnt_q) == MAX_RESULTS);
	assign sts.span_last = (int'(span_q) == SPAN_BYTES - 1);
	assign sts.diff      = (old_q != new_q);
	assign sts.pend      = (cnt_q != '0);
	assign sts.out_free  = out_free;

endmodule
